FILE: hdl/crf_pkg.sv
// Shared types and constants for the clipped rectangle fill engine.
`default_nettype none

package crf_pkg;

   // Coordinate width inside the engine: offset edges plus extents stay below 2^14.
   localparam int COORD_W = 14;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      OP_FILL    = 2'd0,
      OP_OUTLINE = 2'd1,
      OP_APPEND  = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_ORIGIN_X   = 2'd0,
      REG_ORIGIN_Y   = 2'd1,
      REG_LINE_PITCH = 2'd2
   } reg_index_type;

   typedef struct packed {
      op_type      operation;
      logic [11:0] rect_x;
      logic [11:0] rect_y;
      logic [12:0] rect_width;
      logic [12:0] rect_height;
      logic [31:0] fill_color;
      logic [12:0] thickness;
   } req_type;

   typedef struct packed {
      logic [25:0] pixel_index;
      logic [12:0] span_x;
      logic [12:0] span_y;
      logic [12:0] span_width;
      logic [12:0] span_height;
      logic [31:0] out_color;
      logic        nothing_visible;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic [12:0] w;
      logic [12:0] h;
   } clip_type;

   typedef struct packed {
      logic [11:0] origin_x;
      logic [11:0] origin_y;
      logic [13:0] line_pitch;
   } cfg_type;

   // Controller to datapath.
   typedef struct packed {
      logic       load;
      logic       append;
      logic       issue;
      logic       outline;
      logic [1:0] band;
      logic       band_end;
      logic       item_end;
      logic       clip_ok;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic adv;
      logic done;
   } sts_type;

endpackage

`default_nettype wire

FILE: hdl/crf_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module crf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/crf_csr.sv
// Configuration registers: origin offset and line pitch behind an APB-style port.
`default_nettype none

module crf_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [crf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [crf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [crf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output crf_pkg::cfg_type                      cfg
);

   crf_pkg::reg_index_type index;
   logic                   wr_en;
   logic [11:0]            origin_x_ff;
   logic [11:0]            origin_y_ff;
   logic [13:0]            line_pitch_ff;

   assign index      = crf_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         line_pitch_ff <= '0;
      end else if (wr_en) begin
         case (index)
            crf_pkg::REG_ORIGIN_X:   origin_x_ff   <= csr_pwdata[11:0];
            crf_pkg::REG_ORIGIN_Y:   origin_y_ff   <= csr_pwdata[11:0];
            crf_pkg::REG_LINE_PITCH: line_pitch_ff <= csr_pwdata[13:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         crf_pkg::REG_ORIGIN_X:   csr_prdata = crf_pkg::CSR_DATA_W'(origin_x_ff);
         crf_pkg::REG_ORIGIN_Y:   csr_prdata = crf_pkg::CSR_DATA_W'(origin_y_ff);
         crf_pkg::REG_LINE_PITCH: csr_prdata = crf_pkg::CSR_DATA_W'(line_pitch_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   assign cfg.origin_x   = origin_x_ff;
   assign cfg.origin_y   = origin_y_ff;
   assign cfg.line_pitch = line_pitch_ff;

endmodule

`default_nettype wire

FILE: hdl/crf_ctrl.sv
// Controller: accepts transactions, owns the clip count and sequences clip reads per band.
`default_nettype none

module crf_ctrl #(
   parameter int MAX_CLIPS = 16,
   localparam int AW = (MAX_CLIPS > 1) ? $clog2(MAX_CLIPS) : 1,
   localparam int CW = $clog2(MAX_CLIPS + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire crf_pkg::op_type  req_op,
   output logic                  req_ready,
   input  wire crf_pkg::sts_type sts,
   output crf_pkg::cmd_type      cmd,
   output logic      [AW-1:0]    wr_addr,
   output logic      [AW-1:0]    rd_addr
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type   state_ff;
   logic [CW-1:0] count_ff;
   logic [AW-1:0] clip_ff;
   logic [1:0]    band_ff;
   logic          outline_ff;
   logic          accept;
   logic          full;
   logic          last_clip;
   logic          last_band;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff >= CW'(MAX_CLIPS));
   assign last_clip = (count_ff == '0) || ((CW'(clip_ff) + CW'(1)) == count_ff);
   assign last_band = outline_ff ? (band_ff == 2'd3) : (band_ff == 2'd0);

   always_comb begin
      cmd          = '0;
      cmd.load     = accept && (req_op inside {crf_pkg::OP_FILL, crf_pkg::OP_OUTLINE});
      cmd.append   = accept && (req_op == crf_pkg::OP_APPEND) && !full;
      cmd.issue    = (state_ff == ST_RUN);
      cmd.outline  = outline_ff;
      cmd.band     = band_ff;
      cmd.band_end = last_clip;
      cmd.item_end = last_clip && last_band;
      cmd.clip_ok  = (count_ff != '0);
   end

   assign wr_addr = count_ff[AW-1:0];
   assign rd_addr = clip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         clip_ff    <= '0;
         band_ff    <= '0;
         outline_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_op)
                     crf_pkg::OP_FILL,
                     crf_pkg::OP_OUTLINE: begin
                        outline_ff <= (req_op == crf_pkg::OP_OUTLINE);
                        state_ff   <= ST_SETUP;
                     end
                     crf_pkg::OP_APPEND: begin
                        if (!full) begin
                           count_ff <= count_ff + CW'(1);
                        end
                     end
                     crf_pkg::OP_CLEAR: count_ff <= '0;
                     default: ;
                  endcase
               end
            end
            ST_SETUP: begin
               clip_ff  <= '0;
               band_ff  <= '0;
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               if (sts.adv) begin
                  if (last_clip) begin
                     clip_ff <= '0;
                     band_ff <= band_ff + 2'd1;
                     if (last_band) begin
                        state_ff <= ST_DRAIN;
                     end
                  end else begin
                     clip_ff <= clip_ff + AW'(1);
                  end
               end
            end
            ST_DRAIN: begin
               if (sts.done) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: hdl/crf_datapath.sv
// Datapath: item registers, clip RAM, intersect and index pipeline, result hold and output.
`default_nettype none

module crf_datapath #(
   parameter int MAX_CLIPS = 16,
   localparam int AW = (MAX_CLIPS > 1) ? $clog2(MAX_CLIPS) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire crf_pkg::cmd_type cmd,
   output crf_pkg::sts_type      sts,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [AW-1:0]    rd_addr,
   input  wire crf_pkg::req_type req_data,
   input  wire crf_pkg::cfg_type cfg,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   output crf_pkg::rsp_type      rsp_data
);

   localparam int CRW = crf_pkg::COORD_W;

   // Item registers
   logic [12:0]    x_ff, y_ff, w_ff, h_ff, t_ff;
   logic [31:0]    color_ff;
   logic [CRW-1:0] xr_ff, yb_ff;
   logic [12:0]    t_min_wh, t_sat;

   // Issue stage
   logic [CRW-1:0] rx, ry;
   logic [12:0]    rw, rh;
   logic           adv;

   // Stage 1: token next to RAM read data
   logic           p1_valid_ff, p1_clip_ok_ff, p1_band_end_ff, p1_item_end_ff;
   logic [CRW-1:0] p1_rx_ff, p1_ry_ff, p1_rr_ff, p1_rb_ff;
   logic [$bits(crf_pkg::clip_type)-1:0] ram_rd_data;
   crf_pkg::clip_type clip;
   logic [CRW-1:0] cx, cy, cr, cb, sx_in, sy_in, ex_in, ey_in;

   // Stage 2: overlap corners
   logic           p2_valid_ff, p2_hit_ff, p2_band_end_ff, p2_item_end_ff;
   logic [CRW-1:0] p2_sx_ff, p2_sy_ff, p2_ex_ff, p2_ey_ff;
   logic [27:0]    prod;

   // Stage 3: row product and extents
   logic           p3_valid_ff, p3_hit_ff, p3_band_end_ff, p3_item_end_ff;
   logic [25:0]    p3_prod_ff;
   logic [CRW-1:0] p3_sx_ff, p3_sy_ff;
   logic [12:0]    p3_wid_ff, p3_hgt_ff;

   // Result hold and output
   logic             band_any_ff, pend_valid_ff, flush_ff, rsp_valid_ff;
   crf_pkg::rsp_type pend_ff, rsp_ff, res_new, res_out;
   logic             new_any, make_flag, new_res, push_old, push_last;

   // ---------------- item load and band setup ----------------
   assign t_min_wh = (req_data.rect_width < req_data.rect_height) ?
                     req_data.rect_width : req_data.rect_height;
   assign t_sat    = (req_data.thickness < t_min_wh) ? req_data.thickness : t_min_wh;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff     <= 13'(req_data.rect_x) + 13'(cfg.origin_x);
         y_ff     <= 13'(req_data.rect_y) + 13'(cfg.origin_y);
         w_ff     <= req_data.rect_width;
         h_ff     <= req_data.rect_height;
         t_ff     <= t_sat;
         color_ff <= req_data.fill_color;
      end
      // registered from the loaded item registers, valid from the run phase on
      xr_ff <= CRW'(x_ff) + CRW'(w_ff) - CRW'(t_ff);
      yb_ff <= CRW'(y_ff) + CRW'(h_ff) - CRW'(t_ff);
   end

   // ---------------- issue: select band rectangle ----------------
   always_comb begin
      rx = CRW'(x_ff);
      ry = CRW'(y_ff);
      rw = w_ff;
      rh = h_ff;
      if (cmd.outline) begin
         case (cmd.band)
            2'd0: rh = t_ff;
            2'd1: begin
               ry = yb_ff;
               rh = t_ff;
            end
            2'd2: rw = t_ff;
            2'd3: begin
               rx = xr_ff;
               rw = t_ff;
            end
            default: ;
         endcase
      end
   end

   assign adv     = !rsp_valid_ff || rsp_ready;
   assign sts.adv = adv;

   crf_ram #(
      .WIDTH ($bits(crf_pkg::clip_type)),
      .DEPTH (MAX_CLIPS)
   ) u_clip_ram (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (wr_addr),
      .wr_data ({req_data.rect_x, req_data.rect_y, req_data.rect_width,
                 req_data.rect_height}),
      .rd_en   (adv),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_clip_ok_ff  <= cmd.clip_ok;
         p1_band_end_ff <= cmd.band_end;
         p1_item_end_ff <= cmd.item_end;
         p1_rx_ff       <= rx;
         p1_ry_ff       <= ry;
         p1_rr_ff       <= rx + CRW'(rw);
         p1_rb_ff       <= ry + CRW'(rh);
      end
   end

   // ---------------- stage 1: intersect with clip ----------------
   assign clip  = crf_pkg::clip_type'(ram_rd_data);
   assign cx    = CRW'(clip.x);
   assign cy    = CRW'(clip.y);
   assign cr    = CRW'(clip.x) + CRW'(clip.w);
   assign cb    = CRW'(clip.y) + CRW'(clip.h);
   assign sx_in = (p1_rx_ff > cx) ? p1_rx_ff : cx;
   assign sy_in = (p1_ry_ff > cy) ? p1_ry_ff : cy;
   assign ex_in = (p1_rr_ff < cr) ? p1_rr_ff : cr;
   assign ey_in = (p1_rb_ff < cb) ? p1_rb_ff : cb;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_hit_ff      <= p1_valid_ff && p1_clip_ok_ff && (ex_in > sx_in) && (ey_in > sy_in);
         p2_band_end_ff <= p1_band_end_ff;
         p2_item_end_ff <= p1_item_end_ff;
         p2_sx_ff       <= sx_in;
         p2_sy_ff       <= sy_in;
         p2_ex_ff       <= ex_in;
         p2_ey_ff       <= ey_in;
      end
   end

   // ---------------- stage 2: extents and row product ----------------
   assign prod = 28'(p2_sy_ff) * 28'(cfg.line_pitch);

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (adv) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_hit_ff      <= p2_hit_ff;
         p3_band_end_ff <= p2_band_end_ff;
         p3_item_end_ff <= p2_item_end_ff;
         p3_prod_ff     <= prod[25:0];
         p3_sx_ff       <= p2_sx_ff;
         p3_sy_ff       <= p2_sy_ff;
         p3_wid_ff      <= 13'(p2_ex_ff - p2_sx_ff);
         p3_hgt_ff      <= 13'(p2_ey_ff - p2_sy_ff);
      end
   end

   // ---------------- result hold ----------------
   // Keep the newest result back until the next one or the item end is known,
   // so that the final result can carry last.
   assign new_any   = band_any_ff || p3_hit_ff;
   assign make_flag = p3_band_end_ff && !new_any;
   assign new_res   = p3_valid_ff && (p3_hit_ff || make_flag);
   assign push_old  = adv && new_res && pend_valid_ff;
   assign push_last = adv && flush_ff && pend_valid_ff;
   assign sts.done  = push_last;

   always_comb begin
      res_new           = '0;
      res_new.out_color = color_ff;
      if (p3_hit_ff) begin
         res_new.pixel_index = p3_prod_ff + 26'(p3_sx_ff);
         res_new.span_x      = p3_sx_ff[12:0];
         res_new.span_y      = p3_sy_ff[12:0];
         res_new.span_width  = p3_wid_ff;
         res_new.span_height = p3_hgt_ff;
      end else begin
         res_new.nothing_visible = 1'b1;
      end
   end

   // Mark the held result as final when it leaves on the flush.
   always_comb begin
      res_out      = pend_ff;
      res_out.last = push_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_any_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         flush_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (adv) begin
         if (p3_valid_ff) begin
            band_any_ff <= p3_band_end_ff ? 1'b0 : new_any;
         end
         if (new_res) begin
            pend_valid_ff <= 1'b1;
         end else if (push_last) begin
            pend_valid_ff <= 1'b0;
         end
         if (p3_valid_ff && p3_item_end_ff) begin
            flush_ff <= 1'b1;
         end else if (push_last) begin
            flush_ff <= 1'b0;
         end
         rsp_valid_ff <= push_old || push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && new_res) begin
         pend_ff <= res_new;
      end
      if (push_old || push_last) begin
         rsp_ff <= res_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: hdl/clipped_rect_fill.sv
// Clipped rectangle fill front end: top level joining registers, controller and datapath.
// Append and clear keep the controller idle, so the input stays ready for the next transaction.
// A fill issues max(clip_count,1) clip tests, an outline four times that, one per cycle
// while the output does not stall. Either keeps the input busy until its last result moves
// into the output register, paced by the single clip RAM read port and output stalls.
// Synchronous active-high reset clears the clip count, control state, valid flags and configuration registers to zero.
`default_nettype none

module clipped_rect_fill #(
   parameter int MAX_CLIPS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // input transactions
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire crf_pkg::req_type               req_data,
   // result transactions
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output crf_pkg::rsp_type                    rsp_data,
   // configuration port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [crf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [crf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [crf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);

   localparam int AW = (MAX_CLIPS > 1) ? $clog2(MAX_CLIPS) : 1;

   crf_pkg::cfg_type cfg;
   crf_pkg::cmd_type cmd;
   crf_pkg::sts_type sts;
   logic [AW-1:0]    wr_addr;
   logic [AW-1:0]    rd_addr;

   // Origin and pitch registers; the user must write them only while the engine is idle (not enforced here).
   crf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Controller: takes one transaction at a time, keeps the clip count,
   // and walks the stored clips once per band (one band for a fill,
   // top, bottom, left and right bands for an outline).
   crf_ctrl #(
      .MAX_CLIPS (MAX_CLIPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr)
   );

   // Datapath: offsets the rectangle, reads one clip per cycle, intersects,
   // forms y * pitch + x, and holds the newest result back so the final one
   // of a transaction leaves with last set. The whole pipe stalls while a
   // result sits unaccepted in the output register.
   crf_datapath #(
      .MAX_CLIPS (MAX_CLIPS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .req_data  (req_data),
      .cfg       (cfg),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: hdl/crf_checker.sv
// Port-level checks for the clipped rectangle fill engine and their bind.
`default_nettype none

module crf_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire crf_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire crf_pkg::rsp_type rsp_data
);

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // A fill or outline transaction occupies the engine.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_data.operation == crf_pkg::OP_FILL || req_data.operation == crf_pkg::OP_OUTLINE)
      |=> !req_ready)
      else $error("input accepted during a fill");

   // Clip list edits leave the input ready for the next transaction.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_data.operation == crf_pkg::OP_APPEND || req_data.operation == crf_pkg::OP_CLEAR)
      |=> req_ready)
      else $error("clip edit did not release the input");

   // A flagged result carries no rectangle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.nothing_visible |->
      rsp_data.pixel_index == '0 && rsp_data.span_width == '0 && rsp_data.span_height == '0)
      else $error("flagged result with a rectangle");

   // A visible result is never empty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.nothing_visible |->
      rsp_data.span_width != '0 && rsp_data.span_height != '0)
      else $error("empty span emitted");

endmodule

bind clipped_rect_fill crf_checker u_crf_checker (.*);

`default_nettype wire

FILE: tb/sv/clipped_rect_fill_checker.sv
// Channel monitor for the clipped rectangle fill engine: span prediction and result compare.
module clipped_rect_fill_checker #(
   parameter int MAX_CLIPS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire crf_pkg::req_type               req_data,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire crf_pkg::rsp_type               rsp_data,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [crf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [crf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic                           csr_pready,
   output int                                  mismatch_count,
   output int                                  spans_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [11:0]       origin_x;
   logic [11:0]       origin_y;
   logic [13:0]       line_pitch;
   crf_pkg::clip_type clips [MAX_CLIPS];
   int                clip_total;
   crf_pkg::rsp_type  span_queue [$];

   function automatic string span_text(input crf_pkg::rsp_type s);
      return $sformatf("idx=%0d x=%0d y=%0d w=%0d h=%0d color=%h none=%0b last=%0b",
                       s.pixel_index, s.span_x, s.span_y, s.span_width, s.span_height,
                       s.out_color, s.nothing_visible, s.last);
   endfunction

   // Queue one expected span at the tail.
   task automatic append_span(input crf_pkg::rsp_type s);
      span_queue = {span_queue, s};
   endtask

   // One fill of an already offset box against every stored clip.
   task automatic fill_through_clips(input int unsigned bx, input int unsigned by,
                                     input int unsigned bw, input int unsigned bh,
                                     input logic [31:0] color);
      int unsigned      right, bottom, cx, cy, cr, cb, sx, sy, ex, ey, idx;
      int               hits;
      int               i;
      crf_pkg::rsp_type span;
      right  = bx + bw;
      bottom = by + bh;
      hits   = 0;
      for (i = 0; i < clip_total; i++) begin
         cx = 32'(clips[i].x);
         cy = 32'(clips[i].y);
         cr = cx + 32'(clips[i].w);
         cb = cy + 32'(clips[i].h);
         if (right <= cx || bx >= cr || bottom <= cy || by >= cb) continue;
         sx = (bx > cx) ? bx : cx;
         sy = (by > cy) ? by : cy;
         ex = (right < cr) ? right : cr;
         ey = (bottom < cb) ? bottom : cb;
         if (ex <= sx || ey <= sy) continue;
         idx = sy * 32'(line_pitch) + sx;
         span = '0;
         span.pixel_index = idx[25:0];
         span.span_x      = sx[12:0];
         span.span_y      = sy[12:0];
         span.span_width  = 13'(ex - sx);
         span.span_height = 13'(ey - sy);
         span.out_color   = color;
         append_span(span);
         hits++;
      end
      if (hits == 0) begin
         span = '0;
         span.out_color       = color;
         span.nothing_visible = 1'b1;
         append_span(span);
      end
   endtask

   task automatic predict_item(input crf_pkg::req_type item);
      int unsigned      dx, dy, w, h, t;
      int               first;
      crf_pkg::rsp_type tail;
      first = span_queue.size();
      case (item.operation)
         crf_pkg::OP_APPEND: begin
            if (clip_total < MAX_CLIPS) begin
               clips[clip_total] = {item.rect_x, item.rect_y, item.rect_width,
                                    item.rect_height};
               clip_total++;
            end
         end
         crf_pkg::OP_CLEAR: clip_total = 0;
         default: begin
            dx = 32'(item.rect_x) + 32'(origin_x);
            dy = 32'(item.rect_y) + 32'(origin_y);
            w  = 32'(item.rect_width);
            h  = 32'(item.rect_height);
            if (item.operation == crf_pkg::OP_FILL) begin
               fill_through_clips(dx, dy, w, h, item.fill_color);
            end else begin
               // saturate the band to the shorter side, then top, bottom, left, right
               t = 32'(item.thickness);
               if (w < t) t = w;
               if (h < t) t = h;
               fill_through_clips(dx, dy, w, t, item.fill_color);
               fill_through_clips(dx, dy + h - t, w, t, item.fill_color);
               fill_through_clips(dx, dy, t, h, item.fill_color);
               fill_through_clips(dx + w - t, dy, t, h, item.fill_color);
            end
         end
      endcase
      if (span_queue.size() > first) begin
         tail = span_queue[span_queue.size() - 1];
         tail.last = 1'b1;
         span_queue[span_queue.size() - 1] = tail;
      end
   endtask

   task automatic check_span(input crf_pkg::rsp_type got);
      crf_pkg::rsp_type want;
      string            wrong;
      if (span_queue.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result: %s", span_text(got));
         return;
      end
      want  = span_queue.pop_front();
      wrong = "";
      if (got.pixel_index !== want.pixel_index)         wrong = {wrong, " pixel_index"};
      if (got.span_x !== want.span_x)                   wrong = {wrong, " span_x"};
      if (got.span_y !== want.span_y)                   wrong = {wrong, " span_y"};
      if (got.span_width !== want.span_width)           wrong = {wrong, " span_width"};
      if (got.span_height !== want.span_height)         wrong = {wrong, " span_height"};
      if (got.out_color !== want.out_color)             wrong = {wrong, " out_color"};
      if (got.nothing_visible !== want.nothing_visible) wrong = {wrong, " nothing_visible"};
      if (got.last !== want.last)                       wrong = {wrong, " last"};
      if (wrong != "") begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("result mismatch in%s\n  expected %s\n  actual   %s",
                     wrong, span_text(want), span_text(got));
      end
   endtask

   // Apply register writes first, retire results next, then predict the new transaction.
   always @(posedge clock) begin
      if (reset) begin
         origin_x   = '0;
         origin_y   = '0;
         line_pitch = '0;
         clip_total = 0;
         span_queue.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (crf_pkg::reg_index_type'(csr_paddr[crf_pkg::CSR_ADDR_W-1:2]))
               crf_pkg::REG_ORIGIN_X:   origin_x   = csr_pwdata[11:0];
               crf_pkg::REG_ORIGIN_Y:   origin_y   = csr_pwdata[11:0];
               crf_pkg::REG_LINE_PITCH: line_pitch = csr_pwdata[13:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) check_span(rsp_data);
         if (req_valid && req_ready) predict_item(req_data);
      end
      spans_pending = span_queue.size();
   end

endmodule

FILE: tb/sv/clipped_rect_fill_test.sv
// Top of the clipped rectangle fill testbench: stimulus, result sink and verdict.
module clipped_rect_fill_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_CLIPS = 16;
   localparam int unsigned COORD_MAX = 4095;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AFTER = 150;  // results taken before the long receiver stall

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   crf_pkg::req_type               req_data;
   logic                           rsp_valid;
   logic                           rsp_ready;
   crf_pkg::rsp_type               rsp_data;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [crf_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [crf_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [crf_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;
   int                             failures;
   int                             pending;

   // Stimulus bookkeeping: current origin (to place clips near drawn boxes) and pacing modes.
   logic [11:0] cur_ox;
   logic [11:0] cur_oy;
   bit          send_eager;
   bit          sink_eager;
   int          items_sent;
   int          results_taken;

   clipped_rect_fill #(.MAX_CLIPS(MAX_CLIPS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   clipped_rect_fill_checker #(.MAX_CLIPS(MAX_CLIPS)) span_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (failures),
      .spans_pending  (pending)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic crf_pkg::req_type make_item(input crf_pkg::op_type op,
                                                  input int unsigned x, input int unsigned y,
                                                  input int unsigned w, input int unsigned h,
                                                  input int unsigned color,
                                                  input int unsigned t);
      crf_pkg::req_type item;
      item.operation   = op;
      item.rect_x      = 12'(x);
      item.rect_y      = 12'(y);
      item.rect_width  = 13'(w);
      item.rect_height = 13'(h);
      item.fill_color  = color;
      item.thickness   = 13'(t);
      return item;
   endfunction

   // Every field drawn over its full bit width, operation included.
   function automatic crf_pkg::req_type noise_item();
      return make_item(crf_pkg::op_type'($urandom_range(0, 3)), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 8191),
                       $urandom_range(0, 8191), $urandom, $urandom_range(0, 8191));
   endfunction

   // Clip edge a little past the origin, so that offset boxes land on it.
   function automatic int unsigned near_origin(input logic [11:0] origin);
      int unsigned v;
      v = 32'(origin) + $urandom_range(0, 128);
      return (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   // Mostly modest extents, with empty ones and ones drawn over the full range mixed in.
   function automatic int unsigned draw_extent();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 0;
      if (pick == 1) return $urandom_range(0, 8191);
      return $urandom_range(1, 160);
   endfunction

   function automatic int unsigned draw_band();
      int pick;
      pick = $urandom_range(0, 5);
      if (pick == 0) return 0;
      if (pick == 1) return 8191;
      if (pick == 2) return $urandom_range(0, 8191);
      return $urandom_range(1, 24);
   endfunction

   // Offer one transaction after a random gap; hold valid and payload until accepted.
   task automatic send_item(input crf_pkg::req_type item);
      int gap;
      gap = send_eager ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic write_reg(input crf_pkg::reg_index_type index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Drain the engine, then load a new origin and pitch. Upper data bits carry junk
   // on purpose: the registers must keep only their own width.
   task automatic settle_and_configure(input logic [11:0] ox, input logic [11:0] oy,
                                       input logic [13:0] pitch);
      logic [31:0] word;
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      // appends and clears leave no result behind, so give the pipe time to go quiet
      repeat (SETTLE_CYCLES) @(posedge clock);
      word = $urandom;
      word[11:0] = ox;
      write_reg(crf_pkg::REG_ORIGIN_X, word);
      word = $urandom;
      word[11:0] = oy;
      write_reg(crf_pkg::REG_ORIGIN_Y, word);
      word = $urandom;
      word[13:0] = pitch;
      write_reg(crf_pkg::REG_LINE_PITCH, word);
      cur_ox = ox;
      cur_oy = oy;
   endtask

   // Well-formed burst: optional clear, a run of clips near the origin, then draws.
   task automatic run_sequence();
      int clips_to_add;
      int draws;
      if ($urandom_range(0, 1) != 0)
         send_item(make_item(crf_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom));
      // now and then overrun the clip list
      clips_to_add = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18)
                                                 : $urandom_range(1, 5);
      repeat (clips_to_add)
         send_item(make_item(crf_pkg::OP_APPEND, near_origin(cur_ox), near_origin(cur_oy),
                             draw_extent(), draw_extent(), $urandom, $urandom));
      draws = $urandom_range(1, 4);
      repeat (draws)
         send_item(make_item(($urandom_range(0, 1) != 0) ? crf_pkg::OP_OUTLINE
                                                         : crf_pkg::OP_FILL,
                             $urandom_range(0, 96), $urandom_range(0, 96),
                             draw_extent(), draw_extent(), $urandom, draw_band()));
   endtask

   task automatic random_phase(input int count);
      int target;
      target = items_sent + count;
      send_eager = ($urandom_range(0, 3) == 0);
      while (items_sent < target) begin
         if ($urandom_range(0, 2) == 0) send_item(noise_item());
         else run_sequence();
      end
   endtask

   // Stimulus and verdict.
   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      cur_ox      = '0;
      cur_oy      = '0;
      send_eager  = 1'b0;
      items_sent  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: widest pitch so that large indexes wrap.
      settle_and_configure(12'd0, 12'd0, 14'h3FFF);
      send_item(make_item(crf_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0));
      // no clips at all: flagged results, one per fill and one per outline band
      send_item(make_item(crf_pkg::OP_FILL, 0, 0, 10, 10, 32'h1234_5678, 0));
      send_item(make_item(crf_pkg::OP_OUTLINE, 5, 5, 20, 20, 32'h0BAD_F00D, 3));
      // zero-width and zero-height clips never overlap
      send_item(make_item(crf_pkg::OP_APPEND, 0, 0, 0, 4096, 0, 0));
      send_item(make_item(crf_pkg::OP_APPEND, 10, 10, 4096, 0, 0, 0));
      send_item(make_item(crf_pkg::OP_FILL, 0, 0, 100, 100, 32'hA5A5_A5A5, 0));
      send_item(make_item(crf_pkg::OP_APPEND, 0, 0, 4096, 4096, 0, 0));
      send_item(make_item(crf_pkg::OP_APPEND, 4095, 4095, 4096, 4096, 0, 0));
      send_item(make_item(crf_pkg::OP_APPEND, 100, 0, 8191, 8191, 0, 0));
      // far corner at full extent, all-ones color
      send_item(make_item(crf_pkg::OP_FILL, 4095, 4095, 4096, 4096, 32'hFFFF_FFFF, 8191));
      // right edge touching a clip's left edge is rejected
      send_item(make_item(crf_pkg::OP_FILL, 0, 0, 100, 10, 32'h0000_0001, 0));
      send_item(make_item(crf_pkg::OP_FILL, 0, 0, 0, 50, 32'h0000_0002, 0));
      send_item(make_item(crf_pkg::OP_FILL, 0, 0, 50, 0, 32'h0000_0003, 0));
      // thickness above both sides saturates; zero thickness gives empty bands
      send_item(make_item(crf_pkg::OP_OUTLINE, 0, 0, 50, 30, 32'h0000_0004, 8191));
      send_item(make_item(crf_pkg::OP_OUTLINE, 200, 300, 40, 40, 32'h0000_0005, 0));
      send_item(make_item(crf_pkg::OP_OUTLINE, 4095, 4095, 8191, 8191, 32'h0, 1));
      send_item(make_item(crf_pkg::OP_FILL, 4095, 0, 8191, 1, 32'h8000_0000, 0));
      send_item(make_item(crf_pkg::OP_FILL, 0, 4095, 1, 4096, 32'h7FFF_FFFF, 0));
      send_item(make_item(crf_pkg::OP_CLEAR, 4095, 4095, 8191, 8191, 32'hFFFF_FFFF, 8191));
      send_item(make_item(crf_pkg::OP_FILL, 0, 0, 64, 64, 32'hC0FF_EE00, 0));
      send_item(make_item(crf_pkg::OP_OUTLINE, 4095, 4095, 8191, 8191, 32'h5555_AAAA, 8191));

      // Random part across several settings, extremes first.
      settle_and_configure(12'd0, 12'd0, 14'd1024);
      random_phase(38);
      settle_and_configure(12'hFFF, 12'hFFF, 14'h3FFF);
      random_phase(38);
      settle_and_configure(12'd17, 12'd3, 14'd0);
      random_phase(38);
      settle_and_configure(12'hFFF, 12'd0, 14'd8192);
      random_phase(38);
      settle_and_configure(12'd0, 12'hFFF, 14'd640);
      random_phase(38);
      repeat (3) begin
         settle_and_configure(12'($urandom), 12'($urandom), 14'($urandom));
         random_phase(38);
      end

      // Drop valid, drain, and let any stray result show up before the verdict.
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Result sink: random stalls per result, bursts with no stall, and one long
   // hold-off while the sender keeps offering so that the engine backs up.
   initial begin : result_sink
      int  stall;
      bit  held_off;
      rsp_ready     <= 1'b0;
      held_off      = 1'b0;
      sink_eager    = 1'b0;
      results_taken = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (results_taken % 32 == 0) sink_eager = ($urandom_range(0, 3) == 0);
         stall = sink_eager ? 0 : $urandom_range(0, 3);
         if (!held_off && results_taken >= HOLD_OFF_AFTER) begin
            held_off = 1'b1;
            stall    = HOLD_OFF_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         results_taken++;
      end
   end

   // Watchdog: several times the slowest correct run.
   initial begin
      #6ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: files.f
hdl/crf_pkg.sv
hdl/crf_ram.sv
hdl/crf_csr.sv
hdl/crf_ctrl.sv
hdl/crf_datapath.sv
hdl/clipped_rect_fill.sv
hdl/crf_checker.sv
tb/sv/clipped_rect_fill_checker.sv
tb/sv/clipped_rect_fill_test.sv
